FILE: rtl/vcsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsr_pkg: shared types and constants of the voxel column span renderer
// register codes, fog colour, queue sizes and the words that move between parts
// ----------------------------------------------------------------------------
package vcsr_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_SCREEN_ROWS  = 3'd0;
    localparam logic [2:0] REG_HORIZON_ROW  = 3'd1;
    localparam logic [2:0] REG_EYE_HEIGHT   = 3'd2;
    localparam logic [2:0] REG_HEIGHT_SCALE = 3'd3;
    localparam logic [2:0] REG_WATER_LEVEL  = 3'd4;

    // register reset values
    localparam logic [10:0] RST_SCREEN_ROWS  = 11'd240;
    localparam logic [9:0]  RST_HORIZON_ROW  = 10'd100;
    localparam logic [9:0]  RST_EYE_HEIGHT   = 10'd200;
    localparam logic [15:0] RST_HEIGHT_SCALE = 16'd30720;
    localparam logic [7:0]  RST_WATER_LEVEL  = 8'd70;

    // fixed fog colour
    localparam logic [7:0] FOG_R = 8'd174;
    localparam logic [7:0] FOG_G = 8'd190;
    localparam logic [7:0] FOG_B = 8'd196;

    // queue between front and back, and result queue
    localparam int MID_DEPTH = 8;
    localparam int MID_CW    = $clog2(MID_DEPTH + 1);
    localparam int RES_DEPTH = 4;
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic [10:0] screen_rows;
        logic [9:0]  horizon_row;
        logic [9:0]  eye_height;
        logic [15:0] height_scale;
        logic [7:0]  water_level;
    } t_cfg;

    // one raw terrain sample
    typedef struct packed {
        logic [8:0]  column;
        logic        first_row;
        logic [7:0]  ground_height;
        logic [16:0] inv_distance;
        logic [8:0]  fog_level;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_sample;

    // projected sample, front to back
    typedef struct packed {
        logic [8:0]  column;
        logic        first_row;
        logic [10:0] top;
        logic [10:0] rows;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_item;

    // one span result
    typedef struct packed {
        logic [8:0]  column;
        logic [10:0] top;
        logic [10:0] bottom;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_span;

endpackage

FILE: rtl/vcsr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsr_fifo: small show-ahead queue
// register array with head word on the output; depth is a power of two and
// the writer never pushes into a full queue
// ----------------------------------------------------------------------------
module vcsr_fifo #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && w_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/vcsr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsr_front: sample classification, projection and fog blend
// three registered stages; drops out-of-range columns and hands a projected
// word with its top row and fogged colour to the middle queue
// ----------------------------------------------------------------------------
module vcsr_front #(
    parameter int SCREEN_COLUMNS = 512,
    parameter int MAX_ROWS       = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vcsr_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  vcsr_pkg::t_sample i_sample,
    output logic              o_valid,
    output vcsr_pkg::t_item   o_item,
    output logic [1:0]        o_inflight
);

    // effective row count and horizon
    logic [12:0] w_rows13;
    logic [10:0] w_rows;
    logic [10:0] w_hor;
    logic [10:0] w_rows_m1;

    always_comb begin
        w_rows13 = {2'b00, i_cfg.screen_rows};
        if (w_rows13 == 13'd0) begin
            w_rows13 = 13'd1;
        end
        if (w_rows13 > 13'(MAX_ROWS)) begin
            w_rows13 = 13'(MAX_ROWS);
        end
        w_rows    = w_rows13[10:0];
        w_rows_m1 = w_rows - 11'd1;
        w_hor     = ({1'b0, i_cfg.horizon_row} > w_rows_m1) ? w_rows_m1
                                                            : {1'b0, i_cfg.horizon_row};
    end

    // input classification
    logic [9:0] w_ground;
    logic       w_neg;
    logic [9:0] w_dmag;
    logic [8:0] w_fog;
    logic       w_in_range;

    always_comb begin
        w_ground   = {2'b00, ((i_sample.ground_height < i_cfg.water_level)
                              ? i_cfg.water_level : i_sample.ground_height)};
        w_neg      = w_ground > i_cfg.eye_height;
        w_dmag     = w_neg ? (w_ground - i_cfg.eye_height) : (i_cfg.eye_height - w_ground);
        w_fog      = (i_sample.fog_level > 9'd256) ? 9'd256 : i_sample.fog_level;
        w_in_range = ({4'b0000, i_sample.column} < 13'(SCREEN_COLUMNS));
    end

    // stage 1 registers
    logic        r_v1;
    logic [8:0]  r_col1;
    logic        r_first1;
    logic        r_neg1;
    logic [9:0]  r_dmag1;
    logic [16:0] r_invd1;
    logic [8:0]  r_fog1;
    logic [7:0]  r_c1 [3];

    // stage 2 registers
    logic        r_v2;
    logic [8:0]  r_col2;
    logic        r_first2;
    logic        r_neg2;
    logic [25:0] r_m1;
    logic [16:0] r_invd2;
    logic [16:0] r_f2;
    logic [7:0]  r_c2 [3];

    // stage 3 registers
    logic        r_v3;
    logic [8:0]  r_col3;
    logic        r_first3;
    logic        r_neg3;
    logic [42:0] r_m2;
    logic [24:0] r_pc [3];
    logic [24:0] r_pf [3];

    logic [7:0]  w_fogc [3];
    logic [16:0] w_w2;
    logic [17:0] w_f2full;

    assign w_fogc[0] = vcsr_pkg::FOG_R;
    assign w_fogc[1] = vcsr_pkg::FOG_G;
    assign w_fogc[2] = vcsr_pkg::FOG_B;
    assign w_f2full  = r_fog1 * r_fog1;
    assign w_w2      = 17'h10000 - r_f2;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid && w_in_range;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // payload pipeline: height difference times scale, then times reciprocal distance; fog weights alongside
    always_ff @(posedge i_clk) begin
        r_col1   <= i_sample.column;
        r_first1 <= i_sample.first_row;
        r_neg1   <= w_neg;
        r_dmag1  <= w_dmag;
        r_invd1  <= i_sample.inv_distance;
        r_fog1   <= w_fog;
        r_c1[0]  <= i_sample.red;
        r_c1[1]  <= i_sample.green;
        r_c1[2]  <= i_sample.blue;

        r_col2   <= r_col1;
        r_first2 <= r_first1;
        r_neg2   <= r_neg1;
        r_m1     <= r_dmag1 * i_cfg.height_scale;
        r_invd2  <= r_invd1;
        r_f2     <= w_f2full[16:0];
        r_c2     <= r_c1;

        r_col3   <= r_col2;
        r_first3 <= r_first2;
        r_neg3   <= r_neg2;
        r_m2     <= r_m1 * r_invd2;
        for (int k = 0; k < 3; k++) begin
            r_pc[k] <= r_c2[k] * w_w2;
            r_pf[k] <= w_fogc[k] * r_f2;
        end
    end

    // projected top row, floor of the signed product, clamped to the screen
    logic [19:0] w_q;
    logic [20:0] w_sum;
    logic [10:0] w_top;

    always_comb begin
        w_q   = {1'b0, r_m2[42:24]} + 20'((r_m2[23:0] != 24'd0) && r_neg3);
        w_sum = {10'd0, w_hor} + {1'b0, w_q};
        if (r_neg3) begin
            w_top = (w_q > {9'd0, w_hor}) ? 11'd0 : (w_hor - w_q[10:0]);
        end else begin
            w_top = (w_sum > {10'd0, w_rows}) ? w_rows : w_sum[10:0];
        end
    end

    // rounded fog blend
    logic [25:0] w_blend [3];
    logic [7:0]  w_cout  [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_blend[k] = {1'b0, r_pc[k]} + {1'b0, r_pf[k]} + 26'd32768;
            w_cout[k]  = (w_blend[k][25:16] > 10'd255) ? 8'd255 : w_blend[k][23:16];
        end
    end

    assign o_valid          = r_v3;
    assign o_item.column    = r_col3;
    assign o_item.first_row = r_first3;
    assign o_item.top       = w_top;
    assign o_item.rows      = w_rows;
    assign o_item.red       = w_cout[0];
    assign o_item.green     = w_cout[1];
    assign o_item.blue      = w_cout[2];
    assign o_inflight       = {1'b0, r_v1} + {1'b0, r_v2} + {1'b0, r_v3};

endmodule

FILE: rtl/vcsr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsr_back: per-column occlusion test and span emit
// reads the column bound from the occlusion memory, forwards the last write,
// lowers the bound and pushes a span word when the sample is visible
// ----------------------------------------------------------------------------
module vcsr_back #(
    parameter int SCREEN_COLUMNS = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  vcsr_pkg::t_item               i_item,
    output logic                          o_pop,
    input  logic [vcsr_pkg::RES_CW-1:0]   i_res_count,
    output logic                          o_push,
    output vcsr_pkg::t_span               o_span
);

    localparam int AW = $clog2(SCREEN_COLUMNS);

    logic [10:0]     r_mem [SCREEN_COLUMNS];
    logic [10:0]     r_rd;
    logic            r_bv;
    vcsr_pkg::t_item r_item;
    logic            r_fw_valid;
    logic [AW-1:0]   r_fw_addr;
    logic [10:0]     r_fw_val;

    logic [12:0]     w_col_in;
    logic [12:0]     w_col_b;
    logic [AW-1:0]   w_raddr;
    logic [AW-1:0]   w_baddr;
    logic [10:0]     w_mbound;
    logic [10:0]     w_bound;
    logic            w_span;
    logic [10:0]     w_wval;

    // take a word only when the result queue has room for it
    assign o_pop    = i_valid && (({1'b0, i_res_count} + {{vcsr_pkg::RES_CW{1'b0}}, r_bv})
                                  < (vcsr_pkg::RES_CW + 1)'(vcsr_pkg::RES_DEPTH));
    assign w_col_in = {4'b0000, i_item.column};
    assign w_col_b  = {4'b0000, r_item.column};
    assign w_raddr  = w_col_in[AW-1:0];
    assign w_baddr  = w_col_b[AW-1:0];

    // bound with forwarding of the write made at the read edge
    always_comb begin
        w_mbound = (r_fw_valid && (r_fw_addr == w_baddr)) ? r_fw_val : r_rd;
        w_bound  = r_item.first_row ? r_item.rows : w_mbound;
        w_span   = r_item.top < w_bound;
        w_wval   = w_span ? r_item.top : w_bound;
    end

    // occlusion memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd <= r_mem[w_raddr];
        end
        if (r_bv) begin
            r_mem[w_baddr] <= w_wval;
        end
    end

    // stage word and forwarding register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        r_fw_addr <= w_baddr;
        r_fw_val  <= w_wval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv       <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            r_bv       <= o_pop;
            r_fw_valid <= r_bv;
        end
    end

    assign o_push        = r_bv && w_span;
    assign o_span.column = r_item.column;
    assign o_span.top    = r_item.top;
    assign o_span.bottom = w_bound;
    assign o_span.red    = r_item.red;
    assign o_span.green  = r_item.green;
    assign o_span.blue   = r_item.blue;

endmodule

FILE: rtl/voxel_column_span_render.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_column_span_render: voxel terrain column span renderer
// throughput: one sample per cycle while full stays low, set by the single read and single write
// port of the per-column occlusion memory
// reset: synchronous, active low; clears queues and valid bits and loads the register reset values;
// the occlusion memory is not cleared, the first distance row writes it
// ----------------------------------------------------------------------------
module voxel_column_span_render #(
    parameter int SCREEN_COLUMNS = 512,
    parameter int MAX_ROWS       = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // sample queue side
    input  logic        push,
    output logic        full,
    input  logic [8:0]  i_column,
    input  logic        i_first_row,
    input  logic [7:0]  i_ground_height,
    input  logic [16:0] i_inv_distance,
    input  logic [8:0]  i_fog_level,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    // span queue side
    output logic        empty,
    input  logic        pop,
    output logic [8:0]  o_span_column,
    output logic [10:0] o_span_top,
    output logic [10:0] o_span_bottom,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out
);

    vcsr_pkg::t_cfg    r_cfg;
    vcsr_pkg::t_sample w_sample;
    logic              w_accept;
    logic              w_fr_valid;
    vcsr_pkg::t_item   w_fr_item;
    logic [1:0]        w_inflight;
    vcsr_pkg::t_item   w_mid_item;
    logic              w_mid_empty;
    logic [vcsr_pkg::MID_CW-1:0] w_mid_count;
    logic              w_bk_pop;
    logic              w_bk_push;
    vcsr_pkg::t_span   w_bk_span;
    vcsr_pkg::t_span   w_res;
    logic [vcsr_pkg::RES_CW-1:0] w_res_count;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_rows  <= vcsr_pkg::RST_SCREEN_ROWS;
            r_cfg.horizon_row  <= vcsr_pkg::RST_HORIZON_ROW;
            r_cfg.eye_height   <= vcsr_pkg::RST_EYE_HEIGHT;
            r_cfg.height_scale <= vcsr_pkg::RST_HEIGHT_SCALE;
            r_cfg.water_level  <= vcsr_pkg::RST_WATER_LEVEL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vcsr_pkg::REG_SCREEN_ROWS:  r_cfg.screen_rows  <= i_cfg_data[10:0];
                vcsr_pkg::REG_HORIZON_ROW:  r_cfg.horizon_row  <= i_cfg_data[9:0];
                vcsr_pkg::REG_EYE_HEIGHT:   r_cfg.eye_height   <= i_cfg_data[9:0];
                vcsr_pkg::REG_HEIGHT_SCALE: r_cfg.height_scale <= i_cfg_data;
                vcsr_pkg::REG_WATER_LEVEL:  r_cfg.water_level  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input word and credit against the middle queue
    assign w_sample.column        = i_column;
    assign w_sample.first_row     = i_first_row;
    assign w_sample.ground_height = i_ground_height;
    assign w_sample.inv_distance  = i_inv_distance;
    assign w_sample.fog_level     = i_fog_level;
    assign w_sample.red           = i_red_in;
    assign w_sample.green         = i_green_in;
    assign w_sample.blue          = i_blue_in;

    assign full     = (({1'b0, w_mid_count} + (vcsr_pkg::MID_CW + 1)'(w_inflight))
                       >= (vcsr_pkg::MID_CW + 1)'(vcsr_pkg::MID_DEPTH));
    assign w_accept = push && !full;

    vcsr_front #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .MAX_ROWS       (MAX_ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (w_accept),
        .i_sample   (w_sample),
        .o_valid    (w_fr_valid),
        .o_item     (w_fr_item),
        .o_inflight (w_inflight)
    );

    // queue between front and back
    vcsr_fifo #(
        .DEPTH (vcsr_pkg::MID_DEPTH),
        .WIDTH ($bits(vcsr_pkg::t_item))
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fr_valid),
        .i_data  (w_fr_item),
        .i_pop   (w_bk_pop),
        .o_data  (w_mid_item),
        .o_empty (w_mid_empty),
        .o_count (w_mid_count)
    );

    vcsr_back #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!w_mid_empty),
        .i_item      (w_mid_item),
        .o_pop       (w_bk_pop),
        .i_res_count (w_res_count),
        .o_push      (w_bk_push),
        .o_span      (w_bk_span)
    );

    // result queue
    vcsr_fifo #(
        .DEPTH (vcsr_pkg::RES_DEPTH),
        .WIDTH ($bits(vcsr_pkg::t_span))
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_bk_push),
        .i_data  (w_bk_span),
        .i_pop   (pop),
        .o_data  (w_res),
        .o_empty (empty),
        .o_count (w_res_count)
    );

    assign o_span_column = w_res.column;
    assign o_span_top    = w_res.top;
    assign o_span_bottom = w_res.bottom;
    assign o_red_out     = w_res.red;
    assign o_green_out   = w_res.green;
    assign o_blue_out    = w_res.blue;

endmodule

FILE: verif/voxel_column_span_render_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_column_span_render_tb: self-checking bench for the column span renderer
// a short table of directed samples, then random phases of front-to-back column
// walks under changing register settings and idle patterns on both queue sides;
// every popped span word is checked, directed rows against table values, the rest against an in-bench projection model
// ----------------------------------------------------------------------------
module voxel_column_span_render_tb;

    localparam int COLS          = 512;
    localparam int ROWS_MAX      = 1024;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 20;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 100;
    localparam int PHASES        = 8;
    localparam int POOL          = 8;
    // no register lives at this index, writes to it must be ignored
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef enum {ROW_CFG, ROW_SAMPLE} t_row_kind;
    typedef enum {CHK_MODEL, CHK_NONE, CHK_SPAN} t_chk;

    typedef struct {
        t_row_kind         kind;
        logic [2:0]        idx;
        logic [15:0]       data;
        vcsr_pkg::t_sample smp;
        t_chk              chk;
        vcsr_pkg::t_span   span;
    } t_dir_row;

    // what the checker should expect for one accepted sample
    typedef struct {
        bit              typed;
        bit              has_span;
        vcsr_pkg::t_span span;
    } t_sample_note;

    typedef struct {
        logic [2:0]  idx;
        logic [15:0] data;
    } t_reg_wr;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [8:0]  i_column = '0;
    logic        i_first_row = 1'b0;
    logic [7:0]  i_ground_height = '0;
    logic [16:0] i_inv_distance = '0;
    logic [8:0]  i_fog_level = '0;
    logic [7:0]  i_red_in = '0;
    logic [7:0]  i_green_in = '0;
    logic [7:0]  i_blue_in = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [8:0]  o_span_column;
    logic [10:0] o_span_top;
    logic [10:0] o_span_bottom;
    logic [7:0]  o_red_out;
    logic [7:0]  o_green_out;
    logic [7:0]  o_blue_out;

    voxel_column_span_render #(
        .SCREEN_COLUMNS(COLS),
        .MAX_ROWS      (ROWS_MAX)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_column       (i_column),
        .i_first_row    (i_first_row),
        .i_ground_height(i_ground_height),
        .i_inv_distance (i_inv_distance),
        .i_fog_level    (i_fog_level),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .empty          (empty),
        .pop            (pop),
        .o_span_column  (o_span_column),
        .o_span_top     (o_span_top),
        .o_span_bottom  (o_span_bottom),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out)
    );

    // model state: register copy and per-column occlusion bounds
    vcsr_pkg::t_cfg cfg_model;
    logic [10:0]    bound_mem [COLS];

    vcsr_pkg::t_span spans_pending [$];
    t_sample_note    sample_notes [$];
    t_dir_row        dir_table [$];
    t_reg_wr         reg_writes [$];

    // stimulus bookkeeping
    bit          touched [COLS];
    logic [8:0]  col_pool [POOL];
    int unsigned invd_track [POOL];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int samples_taken  = 0;
    int spans_expected = 0;
    int spans_checked  = 0;
    int settings_used  = 0;
    int quiet          = 0;

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // fogged channel, rounded half up
    function automatic logic [7:0] fog_mix(input logic [7:0] c, input logic [7:0] fc,
                                           input int unsigned f2);
        longint unsigned cv, fv, v;
        cv = 64'(c);
        fv = 64'(fc);
        v = (cv * (64'd65536 - 64'(f2)) + fv * 64'(f2) + 64'd32768) >> 16;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // project one sample, update the bound store, return 1 when a span results
    function automatic bit project_sample(input vcsr_pkg::t_sample s,
                                          output vcsr_pkg::t_span sp);
        int unsigned     nrows, hor, grnd, eye, bnd, top, fg, f2;
        longint unsigned mag, q;
        longint          proj;
        bit              neg;
        sp = '0;
        if (s.column >= COLS) return 0;
        nrows = 32'(cfg_model.screen_rows);
        if (nrows < 1) nrows = 1;
        if (nrows > ROWS_MAX) nrows = ROWS_MAX;
        hor = 32'(cfg_model.horizon_row);
        if (hor > nrows - 1) hor = nrows - 1;
        grnd = 32'(s.ground_height);
        if (grnd < cfg_model.water_level) grnd = 32'(cfg_model.water_level);
        eye = 32'(cfg_model.eye_height);
        neg = grnd > eye;
        mag = 64'(neg ? grnd - eye : eye - grnd);
        mag = mag * 64'(cfg_model.height_scale) * 64'(s.inv_distance);
        // round the magnitude up when above the horizon line, so the sum floors
        if (neg) begin
            q = (mag + 64'hFF_FFFF) >> 24;
            proj = longint'(hor) - longint'(q);
        end else begin
            q = mag >> 24;
            proj = longint'(hor) + longint'(q);
        end
        if (proj < 0) proj = 0;
        if (proj > longint'(nrows)) proj = longint'(nrows);
        top = 32'(proj);
        bnd = s.first_row ? nrows : 32'(bound_mem[s.column]);
        if (top >= bnd) begin
            bound_mem[s.column] = 11'(bnd);
            return 0;
        end
        fg = 32'(s.fog_level);
        if (fg > 256) fg = 256;
        f2 = fg * fg;
        bound_mem[s.column] = 11'(top);
        sp.column = s.column;
        sp.top    = 11'(top);
        sp.bottom = 11'(bnd);
        sp.red    = fog_mix(s.red, vcsr_pkg::FOG_R, f2);
        sp.green  = fog_mix(s.green, vcsr_pkg::FOG_G, f2);
        sp.blue   = fog_mix(s.blue, vcsr_pkg::FOG_B, f2);
        return 1;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // monitor: register writes, accepted samples and popped span words
    always @(posedge i_clk) begin : monitor
        vcsr_pkg::t_sample smp;
        vcsr_pkg::t_span   pred;
        vcsr_pkg::t_span   want;
        t_sample_note      nt;
        bit                hit;
        bit                moved;
        if (!i_rst_n) begin
            cfg_model.screen_rows  = vcsr_pkg::RST_SCREEN_ROWS;
            cfg_model.horizon_row  = vcsr_pkg::RST_HORIZON_ROW;
            cfg_model.eye_height   = vcsr_pkg::RST_EYE_HEIGHT;
            cfg_model.height_scale = vcsr_pkg::RST_HEIGHT_SCALE;
            cfg_model.water_level  = vcsr_pkg::RST_WATER_LEVEL;
            quiet = 0;
        end else begin
            moved = 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vcsr_pkg::REG_SCREEN_ROWS:  cfg_model.screen_rows  = i_cfg_data[10:0];
                    vcsr_pkg::REG_HORIZON_ROW:  cfg_model.horizon_row  = i_cfg_data[9:0];
                    vcsr_pkg::REG_EYE_HEIGHT:   cfg_model.eye_height   = i_cfg_data[9:0];
                    vcsr_pkg::REG_HEIGHT_SCALE: cfg_model.height_scale = i_cfg_data[15:0];
                    vcsr_pkg::REG_WATER_LEVEL:  cfg_model.water_level  = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // sample accepted
            if (push && !full) begin
                moved = 1'b1;
                samples_taken++;
                smp.column        = i_column;
                smp.first_row     = i_first_row;
                smp.ground_height = i_ground_height;
                smp.inv_distance  = i_inv_distance;
                smp.fog_level     = i_fog_level;
                smp.red           = i_red_in;
                smp.green         = i_green_in;
                smp.blue          = i_blue_in;
                hit = project_sample(smp, pred);
                nt.typed = 1'b0;
                if (sample_notes.size() != 0) nt = sample_notes.pop_front();
                if (nt.typed) begin
                    hit  = nt.has_span;
                    pred = nt.span;
                end
                if (hit) begin
                    spans_pending.push_back(pred);
                    spans_expected++;
                end
            end
            // span word popped
            if (pop && !empty) begin
                moved = 1'b1;
                if (spans_pending.size() == 0) begin
                    $error("span word (col %0d top %0d) popped with none expected",
                           o_span_column, o_span_top);
                    fail_count++;
                end else begin
                    want = spans_pending.pop_front();
                    spans_checked++;
                    check_field("span_column", 32'(want.column), 32'(o_span_column));
                    check_field("span_top", 32'(want.top), 32'(o_span_top));
                    check_field("span_bottom", 32'(want.bottom), 32'(o_span_bottom));
                    check_field("red_out", 32'(want.red), 32'(o_red_out));
                    check_field("green_out", 32'(want.green), 32'(o_green_out));
                    check_field("blue_out", 32'(want.blue), 32'(o_blue_out));
                end
            end
            // watchdog on forward progress
            quiet = moved ? 0 : quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $error("no word moved for %0d cycles", QUIET_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver: pop with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // present one sample and hold it until accepted
    task automatic send_sample(input vcsr_pkg::t_sample s, input t_sample_note n);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        if (s.first_row) touched[s.column] = 1'b1;
        sample_notes.push_back(n);
        push            <= 1'b1;
        i_column        <= s.column;
        i_first_row     <= s.first_row;
        i_ground_height <= s.ground_height;
        i_inv_distance  <= s.inv_distance;
        i_fog_level     <= s.fog_level;
        i_red_in        <= s.red;
        i_green_in      <= s.green;
        i_blue_in       <= s.blue;
        do @(posedge i_clk); while (full);
    endtask

    // wait until every sample is through, including those that make no span
    task automatic wait_idle();
        push <= 1'b0;
        while (spans_pending.size() != 0 || sample_notes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apply the queued register writes back to back while the block is idle
    task automatic write_regs();
        t_reg_wr w;
        wait_idle();
        while (reg_writes.size() != 0) begin
            w = reg_writes.pop_front();
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= w.idx;
            i_cfg_data <= w.data;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic tbl_cfg(input logic [2:0] idx, input logic [15:0] data);
        t_dir_row r;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        r.smp  = '0;
        r.chk  = CHK_NONE;
        r.span = '0;
        dir_table.push_back(r);
    endtask

    task automatic tbl_smp(input int col, input int first, input int gnd, input int invd,
                           input int fog, input int rd, input int gr, input int bl,
                           input t_chk chk, input int top, input int bot,
                           input int ro, input int go, input int bo);
        t_dir_row r;
        r.kind              = ROW_SAMPLE;
        r.idx               = '0;
        r.data              = '0;
        r.smp.column        = 9'(col);
        r.smp.first_row     = 1'(first);
        r.smp.ground_height = 8'(gnd);
        r.smp.inv_distance  = 17'(invd);
        r.smp.fog_level     = 9'(fog);
        r.smp.red           = 8'(rd);
        r.smp.green         = 8'(gr);
        r.smp.blue          = 8'(bl);
        r.chk               = chk;
        r.span.column       = 9'(col);
        r.span.top          = 11'(top);
        r.span.bottom       = 11'(bot);
        r.span.red          = 8'(ro);
        r.span.green        = 8'(go);
        r.span.blue         = 8'(bo);
        dir_table.push_back(r);
    endtask

    // queue one register write with random junk above the register width
    task automatic queue_reg(input logic [2:0] idx, input int unsigned val,
                             input int unsigned mask);
        t_reg_wr w;
        w.idx  = idx;
        w.data = 16'(($urandom_range(0, 65535) & ~mask) | (val & mask));
        reg_writes.push_back(w);
    endtask

    // random settings for one phase, extremes mixed in
    task automatic pick_settings();
        int unsigned rows_v, eff, hor_v, eye_v, scale_v, water_v;
        case ($urandom_range(0, 9))
            0:       rows_v = 0;
            1:       rows_v = $urandom_range(1025, 2047);
            2:       rows_v = 1024;
            3:       rows_v = 1;
            default: rows_v = $urandom_range(2, 1024);
        endcase
        eff = (rows_v < 1) ? 1 : (rows_v > ROWS_MAX) ? ROWS_MAX : rows_v;
        hor_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                            : $urandom_range(0, eff - 1);
        case ($urandom_range(0, 7))
            0:       eye_v = 0;
            1:       eye_v = 1023;
            default: eye_v = $urandom_range(0, 1023);
        endcase
        case ($urandom_range(0, 7))
            0:       scale_v = 1;
            1:       scale_v = 65535;
            2, 3:    scale_v = $urandom_range(1, 65535);
            default: scale_v = $urandom_range(64, 8192);
        endcase
        case ($urandom_range(0, 7))
            0:       water_v = 0;
            1:       water_v = 255;
            default: water_v = $urandom_range(0, 255);
        endcase
        queue_reg(vcsr_pkg::REG_SCREEN_ROWS, rows_v, 16'h07FF);
        queue_reg(vcsr_pkg::REG_HORIZON_ROW, hor_v, 16'h03FF);
        queue_reg(vcsr_pkg::REG_EYE_HEIGHT, eye_v, 16'h03FF);
        queue_reg(vcsr_pkg::REG_HEIGHT_SCALE, scale_v, 16'hFFFF);
        queue_reg(vcsr_pkg::REG_WATER_LEVEL, water_v, 16'h00FF);
        if ($urandom_range(0, 3) == 0) queue_reg(REG_UNUSED, $urandom_range(0, 65535), 16'hFFFF);
    endtask

    // mostly front-to-back walks over a few columns, the rest noise
    task automatic make_sample(output vcsr_pkg::t_sample s);
        int          k;
        int unsigned step;
        k = $urandom_range(0, POOL - 1);
        s.ground_height = 8'($urandom_range(0, 255));
        s.red           = 8'($urandom_range(0, 255));
        s.green         = 8'($urandom_range(0, 255));
        s.blue          = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 85) begin
            s.column = col_pool[k];
            if (!touched[s.column] || invd_track[k] == 0 || $urandom_range(0, 39) == 0) begin
                s.first_row   = 1'b1;
                invd_track[k] = $urandom_range(4096, 65536);
            end else begin
                s.first_row = 1'b0;
                step = invd_track[k] / 8 + $urandom_range(0, 15);
                invd_track[k] = (step >= invd_track[k]) ? 0 : invd_track[k] - step;
            end
            s.inv_distance = 17'(invd_track[k]);
            s.fog_level    = 9'($urandom_range(0, 256));
        end else begin
            s.column       = 9'($urandom_range(0, COLS - 1));
            s.first_row    = touched[s.column] ? 1'($urandom_range(0, 1)) : 1'b1;
            s.inv_distance = 17'($urandom_range(0, 131071));
            s.fog_level    = 9'($urandom_range(0, 511));
        end
    endtask

    // main sequence
    initial begin
        int                i, ph, n;
        vcsr_pkg::t_sample s;
        t_sample_note      nt;

        // directed table, after reset: 240 rows, horizon 100, eye 200, scale 120.0
        tbl_smp(0, 1, 0, 0, 0, 10, 20, 30, CHK_SPAN, 100, 240, 10, 20, 30);
        tbl_smp(511, 1, 255, 0, 256, 255, 255, 255, CHK_SPAN, 100, 240, 174, 190, 196);
        tbl_smp(0, 0, 0, 0, 0, 5, 5, 5, CHK_NONE, 0, 0, 0, 0, 0);
        tbl_smp(0, 0, 255, 65536, 0, 1, 2, 3, CHK_SPAN, 0, 100, 1, 2, 3);
        tbl_smp(511, 0, 0, 131071, 511, 9, 9, 9, CHK_NONE, 0, 0, 0, 0, 0);
        tbl_smp(5, 1, 128, 1, 128, 0, 128, 255, CHK_MODEL, 0, 0, 0, 0, 0);
        tbl_smp(5, 0, 200, 100, 0, 77, 88, 99, CHK_MODEL, 0, 0, 0, 0, 0);
        tbl_smp(5, 0, 255, 256, 200, 200, 100, 50, CHK_MODEL, 0, 0, 0, 0, 0);
        // zero rows taken as one, horizon clamped into the screen
        tbl_cfg(vcsr_pkg::REG_SCREEN_ROWS, 16'hF800);
        tbl_cfg(vcsr_pkg::REG_HORIZON_ROW, 16'h03FF);
        tbl_smp(7, 1, 255, 65536, 0, 9, 9, 9, CHK_SPAN, 0, 1, 9, 9, 9);
        tbl_smp(7, 1, 0, 0, 300, 0, 0, 0, CHK_SPAN, 0, 1, 174, 190, 196);
        // row count above the maximum, everything at the top of its range
        tbl_cfg(vcsr_pkg::REG_SCREEN_ROWS, 16'h07FF);
        tbl_cfg(vcsr_pkg::REG_EYE_HEIGHT, 16'h03FF);
        tbl_cfg(vcsr_pkg::REG_HEIGHT_SCALE, 16'hFFFF);
        tbl_cfg(vcsr_pkg::REG_WATER_LEVEL, 16'h00FF);
        tbl_cfg(REG_UNUSED, 16'h1234);
        tbl_smp(100, 1, 0, 0, 0, 40, 50, 60, CHK_SPAN, 1023, 1024, 40, 50, 60);
        tbl_smp(100, 0, 0, 131071, 0, 1, 1, 1, CHK_NONE, 0, 0, 0, 0, 0);
        tbl_smp(100, 0, 255, 1, 0, 1, 1, 1, CHK_NONE, 0, 0, 0, 0, 0);
        // bottom extremes: a tiny negative projection still floors one row up
        tbl_cfg(vcsr_pkg::REG_EYE_HEIGHT, 16'h0000);
        tbl_cfg(vcsr_pkg::REG_WATER_LEVEL, 16'h0000);
        tbl_cfg(vcsr_pkg::REG_HEIGHT_SCALE, 16'h0001);
        tbl_cfg(vcsr_pkg::REG_HORIZON_ROW, 16'd512);
        tbl_cfg(vcsr_pkg::REG_SCREEN_ROWS, 16'd1024);
        tbl_smp(200, 1, 1, 1, 0, 7, 8, 9, CHK_SPAN, 511, 1024, 7, 8, 9);
        tbl_smp(200, 0, 0, 131071, 256, 1, 1, 1, CHK_NONE, 0, 0, 0, 0, 0);
        tbl_smp(200, 0, 255, 131071, 64, 128, 128, 128, CHK_MODEL, 0, 0, 0, 0, 0);
        tbl_cfg(vcsr_pkg::REG_HORIZON_ROW, 16'h0000);
        tbl_cfg(vcsr_pkg::REG_HEIGHT_SCALE, 16'hFFFF);
        tbl_cfg(vcsr_pkg::REG_EYE_HEIGHT, 16'h03FF);
        tbl_smp(511, 1, 0, 65536, 256, 3, 3, 3, CHK_NONE, 0, 0, 0, 0, 0);
        tbl_smp(0, 1, 128, 8, 1, 255, 0, 255, CHK_MODEL, 0, 0, 0, 0, 0);

        // reset
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling
        for (i = 0; i < dir_table.size(); i++) begin
            if (dir_table[i].kind == ROW_CFG) begin
                reg_writes.push_back('{idx: dir_table[i].idx, data: dir_table[i].data});
                if (i + 1 == dir_table.size() || dir_table[i + 1].kind != ROW_CFG)
                    write_regs();
            end else begin
                nt.typed    = (dir_table[i].chk != CHK_MODEL);
                nt.has_span = (dir_table[i].chk == CHK_SPAN);
                nt.span     = dir_table[i].span;
                send_sample(dir_table[i].smp, nt);
            end
        end

        // random phases, idle pattern rotating through the four modes
        nt.typed    = 1'b0;
        nt.has_span = 1'b0;
        nt.span     = '0;
        ph = 0;
        while (ph < PHASES) begin
            pick_settings();
            write_regs();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            for (n = 0; n < POOL; n++) begin
                col_pool[n]   = 9'($urandom_range(0, COLS - 1));
                invd_track[n] = 0;
            end
            if ($urandom_range(0, 3) == 0) begin
                col_pool[0] = '0;
                col_pool[1] = 9'(COLS - 1);
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                make_sample(s);
                send_sample(s, nt);
            end
            ph++;
        end

        // drain
        push <= 1'b0;
        while (spans_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d samples and %0d of %0d span words over %0d register settings,",
                 samples_taken, spans_checked, spans_expected, settings_used);
        $display("with both queue sides idling and stalling in turn");
        if (fail_count == 0 && spans_pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
